### rtl/assert_macros.svh
// Assertion macros shared by the RTL of the DRAM address mapper.
// Define NO_ASSERTIONS to compile every assertion out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication checked on every rising clock edge outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

### rtl/dxam_pkg.sv
// Constants, XOR matrices and field packing helpers of the DRAM address mapper.
// No dependencies.
package dxam_pkg;

	localparam int MAPPED_BITS = 30;
	localparam int BANK_W      = 5;
	localparam int ROW_W       = 13;
	localparam int COL_W       = 13;
	localparam int BASE_W      = 34;
	localparam int ADDR_W      = 64;
	localparam int S_DATA_W    = 64;
	localparam int M_DATA_W    = 96;
	localparam int CFG_IDX_W   = 1;

	typedef logic [MAPPED_BITS-1:0] word_t;
	typedef word_t mtx_t [MAPPED_BITS];

	typedef enum logic {
		OP_FWD = 1'b0,
		OP_REV = 1'b1
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DUAL_RANK = 1'b0,
		REG_BASE_PAGE = 1'b1
	} reg_idx_t;

	localparam word_t B0  = word_t'(1) << 0;
	localparam word_t B1  = word_t'(1) << 1;
	localparam word_t B2  = word_t'(1) << 2;
	localparam word_t B3  = word_t'(1) << 3;
	localparam word_t B4  = word_t'(1) << 4;
	localparam word_t B5  = word_t'(1) << 5;
	localparam word_t B6  = word_t'(1) << 6;
	localparam word_t B7  = word_t'(1) << 7;
	localparam word_t B8  = word_t'(1) << 8;
	localparam word_t B9  = word_t'(1) << 9;
	localparam word_t B10 = word_t'(1) << 10;
	localparam word_t B11 = word_t'(1) << 11;
	localparam word_t B12 = word_t'(1) << 12;
	localparam word_t B13 = word_t'(1) << 13;
	localparam word_t B14 = word_t'(1) << 14;
	localparam word_t B15 = word_t'(1) << 15;
	localparam word_t B16 = word_t'(1) << 16;
	localparam word_t B17 = word_t'(1) << 17;
	localparam word_t B18 = word_t'(1) << 18;
	localparam word_t B19 = word_t'(1) << 19;
	localparam word_t B20 = word_t'(1) << 20;
	localparam word_t B21 = word_t'(1) << 21;
	localparam word_t B22 = word_t'(1) << 22;
	localparam word_t B23 = word_t'(1) << 23;
	localparam word_t B24 = word_t'(1) << 24;
	localparam word_t B25 = word_t'(1) << 25;
	localparam word_t B26 = word_t'(1) << 26;
	localparam word_t B27 = word_t'(1) << 27;
	localparam word_t B28 = word_t'(1) << 28;
	localparam word_t B29 = word_t'(1) << 29;

	// Row 0 of each matrix yields the most significant result bit.
	localparam mtx_t FWD_SINGLE = '{
		B13 | B6, B17 | B14, B18 | B15, B19 | B16,
		B12, B11, B10, B9, B8, B7, B6, B5, B4, B3, B2, B1, B0,
		B29, B28, B27, B26, B25, B24, B23, B22, B21, B20, B19, B18, B17
	};
	localparam mtx_t FWD_DUAL = '{
		B13 | B6, B18 | B14, B19 | B15, B20 | B16, B21 | B17,
		B12, B11, B10, B9, B8, B7, B6, B5, B4, B3, B2, B1, B0,
		B29, B28, B27, B26, B25, B24, B23, B22, B21, B20, B19, B18
	};
	localparam mtx_t INV_SINGLE = '{
		B12, B11, B10, B9, B8, B7, B6, B5, B4, B3, B2, B1, B0,
		B26 | B2, B27 | B1, B28 | B0, B29 | B19,
		B25, B24, B23, B22, B21, B20, B19, B18, B17, B16, B15, B14, B13
	};
	localparam mtx_t INV_DUAL = '{
		B11, B10, B9, B8, B7, B6, B5, B4, B3, B2, B1, B0,
		B25 | B3, B26 | B2, B27 | B1, B28 | B0, B29 | B18,
		B24, B23, B22, B21, B20, B19, B18, B17, B16, B15, B14, B13, B12
	};

	// Each result bit is the parity of the word under one row mask.
	function automatic word_t gf2_apply(input op_t op, input logic dual, input word_t v);
		word_t acc;
		word_t row;
		acc = '0;
		for (int i = 0; i < MAPPED_BITS; i++) begin
			case ({op, dual})
				2'b00:   row = FWD_SINGLE[i];
				2'b01:   row = FWD_DUAL[i];
				2'b10:   row = INV_SINGLE[i];
				default: row = INV_DUAL[i];
			endcase
			acc[MAPPED_BITS-1-i] = ^(v & row);
		end
		return acc;
	endfunction

	// Mask bank, row and column to the layout in use and place them at their shifts.
	function automatic word_t pack_fields(input logic dual, input logic [BANK_W-1:0] bank,
			input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col);
		word_t w;
		if (dual) begin
			w = {bank, col, row[11:0]};
		end else begin
			w = {bank[3:0], col, row};
		end
		return w;
	endfunction

endpackage

### rtl/dram_xor_address_mapper.sv
// Throughput: one request per cycle; each stage holds while the one after it is full and cannot move on.
// Stages: input masking and packing, XOR matrix product, field split or base page attach into the output register.
// Reset: arst_n clears all valid bits and both configuration registers at once.
// Depends on dxam_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dram_xor_address_mapper (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [dxam_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [dxam_pkg::BASE_W-1:0]       cfg_wdata,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// address_low [29:0], bank_in [34:30], row_in [47:35], col_in [60:48], zero [63:61]
	input  logic [dxam_pkg::S_DATA_W-1:0]     s_tdata,
	// op [0]
	input  logic                              s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// bank_out [4:0], row_out [17:5], col_out [30:18], address_out [94:31], zero [95]
	output logic [dxam_pkg::M_DATA_W-1:0]     m_tdata
);

	logic                              dual_rank_q;
	logic [dxam_pkg::BASE_W-1:0]       base_page_q;

	logic                              valid_s1, valid_s2, valid_s3;
	logic                              ready_s1, ready_s2, ready_s3;
	dxam_pkg::op_t                     op_s1, op_s2;
	logic                              dual_s1, dual_s2;
	dxam_pkg::word_t                   v_s1, r_s2;
	logic [dxam_pkg::BANK_W-1:0]       bank_s3;
	logic [dxam_pkg::ROW_W-1:0]        row_s3;
	logic [dxam_pkg::COL_W-1:0]        col_s3;
	logic [dxam_pkg::ADDR_W-1:0]       addr_s3;

	logic [dxam_pkg::MAPPED_BITS-1:0]  in_addr;
	logic [dxam_pkg::BANK_W-1:0]       in_bank;
	logic [dxam_pkg::ROW_W-1:0]        in_row;
	logic [dxam_pkg::COL_W-1:0]        in_col;

	assign in_addr = s_tdata[29:0];
	assign in_bank = s_tdata[34:30];
	assign in_row  = s_tdata[47:35];
	assign in_col  = s_tdata[60:48];

	// A stage takes a new request when it is empty or its contents move on.
	assign ready_s3 = !valid_s3 || m_tready;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign s_tready = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dual_rank_q <= 1'b0;
			base_page_q <= '0;
		end else if (cfg_we) begin
			unique case (dxam_pkg::reg_idx_t'(cfg_index))
				dxam_pkg::REG_DUAL_RANK: dual_rank_q <= cfg_wdata[0];
				dxam_pkg::REG_BASE_PAGE: base_page_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (ready_s1) valid_s1 <= s_tvalid;
			if (ready_s2) valid_s2 <= valid_s1;
			if (ready_s3) valid_s3 <= valid_s2;
		end
	end

	// Stage 1: select the operand; for a reverse request, mask and pack the fields to the layout in use.
	always_ff @(posedge clk) begin
		if (ready_s1 && s_tvalid) begin
			op_s1   <= dxam_pkg::op_t'(s_tuser);
			dual_s1 <= dual_rank_q;
			if (dxam_pkg::op_t'(s_tuser) == dxam_pkg::OP_FWD) begin
				v_s1 <= in_addr;
			end else begin
				v_s1 <= dxam_pkg::pack_fields(dual_rank_q, in_bank, in_row, in_col);
			end
		end
	end

	// Stage 2: matrix product over GF(2).
	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			op_s2   <= op_s1;
			dual_s2 <= dual_s1;
			r_s2    <= dxam_pkg::gf2_apply(op_s1, dual_s1, v_s1);
		end
	end

	// Stage 3: split into fields or attach the base page.
	always_ff @(posedge clk) begin
		if (ready_s3 && valid_s2) begin
			if (op_s2 == dxam_pkg::OP_FWD) begin
				addr_s3 <= '0;
				if (dual_s2) begin
					bank_s3 <= r_s2[29:25];
					col_s3  <= r_s2[24:12];
					row_s3  <= {1'b0, r_s2[11:0]};
				end else begin
					bank_s3 <= {1'b0, r_s2[29:26]};
					col_s3  <= r_s2[25:13];
					row_s3  <= r_s2[12:0];
				end
			end else begin
				bank_s3 <= '0;
				row_s3  <= '0;
				col_s3  <= '0;
				addr_s3 <= {base_page_q, r_s2};
			end
		end
	end

	assign m_tvalid = valid_s3;
	assign m_tdata  = {1'b0, addr_s3, col_s3, row_s3, bank_s3};

	// A result carries either the bank/row/column fields or an address, never both.
	`ASSERT_IMPL(a_one_direction, clk, arst_n, m_tvalid, (m_tdata[94:31] == '0) || (m_tdata[30:0] == '0))
	// An accepted request always lands in the first stage.
	`ASSERT_NEXT(a_accept_lands, clk, arst_n, s_tvalid && s_tready, valid_s1)
	// A full first stage that cannot move on blocks new requests.
	`ASSERT_IMPL(a_hold_blocks, clk, arst_n, valid_s1 && !ready_s2, !s_tready)
	// A held result keeps its contents.
	`ASSERT_NEXT(a_result_held, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

### verif/dram_xor_address_mapper_tb.sv
// Testbench for the DRAM XOR address mapper: forward and reverse requests in both rank modes.
// Predicts every result with its own GF(2) tables and checks the master side field by field.
// Depends on dxam_pkg and the dram_xor_address_mapper RTL.
module dram_xor_address_mapper_tb;
	import dxam_pkg::*;

	localparam int SEL_FWD = 0;
	localparam int SEL_INV = 2;

	typedef struct packed {
		logic [BANK_W-1:0] bank;
		logic [ROW_W-1:0]  row;
		logic [COL_W-1:0]  col;
		logic [ADDR_W-1:0] addr;
	} map_result_t;

	class xor_map_tracker;
		word_t       rows [4][MAPPED_BITS];
		logic        dual;
		logic [BASE_W-1:0] base;
		map_result_t expected_maps [$];
		int          errors;
		int          n_fwd;
		int          n_rev;

		function new();
			// Rows above 99 hold two taps: the digits above the last two give one bit, the last two digits the other.
			load_rows(SEL_FWD, '{1306, 1714, 1815, 1916,
				12, 11, 10, 9, 8, 7, 6, 5, 4, 3, 2, 1, 0,
				29, 28, 27, 26, 25, 24, 23, 22, 21, 20, 19, 18, 17});
			load_rows(SEL_FWD + 1, '{1306, 1814, 1915, 2016, 2117,
				12, 11, 10, 9, 8, 7, 6, 5, 4, 3, 2, 1, 0,
				29, 28, 27, 26, 25, 24, 23, 22, 21, 20, 19, 18});
			load_rows(SEL_INV, '{12, 11, 10, 9, 8, 7, 6, 5, 4, 3, 2, 1, 0,
				2602, 2701, 2800, 2919,
				25, 24, 23, 22, 21, 20, 19, 18, 17, 16, 15, 14, 13});
			load_rows(SEL_INV + 1, '{11, 10, 9, 8, 7, 6, 5, 4, 3, 2, 1, 0,
				2503, 2602, 2701, 2800, 2918,
				24, 23, 22, 21, 20, 19, 18, 17, 16, 15, 14, 13, 12});
			dual   = 1'b0;
			base   = '0;
			errors = 0;
			n_fwd  = 0;
			n_rev  = 0;
		endfunction

		function void load_rows(int sel, int enc [MAPPED_BITS]);
			for (int i = 0; i < MAPPED_BITS; i++) begin
				if (enc[i] >= 100) begin
					rows[sel][i] = (word_t'(1) << (enc[i] / 100)) | (word_t'(1) << (enc[i] % 100));
				end else begin
					rows[sel][i] = word_t'(1) << enc[i];
				end
			end
		endfunction

		// First row drives the top bit of the product.
		function word_t xor_product(int sel, word_t v);
			word_t acc;
			for (int i = 0; i < MAPPED_BITS; i++) begin
				acc[MAPPED_BITS-1-i] = ^(v & rows[sel][i]);
			end
			return acc;
		endfunction

		function void set_reg(reg_idx_t idx, logic [BASE_W-1:0] v);
			case (idx)
				REG_DUAL_RANK: dual = v[0];
				REG_BASE_PAGE: base = v;
			endcase
		endfunction

		function int pending();
			return expected_maps.size();
		endfunction

		function void note_request(op_t op, word_t a, logic [BANK_W-1:0] bk,
				logic [ROW_W-1:0] rw, logic [COL_W-1:0] cl);
			map_result_t m;
			word_t       r;
			m = '0;
			if (op == OP_FWD) begin
				n_fwd++;
				r = xor_product(SEL_FWD + int'(dual), a);
				if (dual) begin
					m.bank = r[29:25];
					m.col  = r[24:12];
					m.row  = {1'b0, r[11:0]};
				end else begin
					m.bank = {1'b0, r[29:26]};
					m.col  = r[25:13];
					m.row  = r[12:0];
				end
			end else begin
				n_rev++;
				// Drop the bits that the rank layout has no room for.
				r = dual ? {bk, cl, rw[11:0]} : {bk[3:0], cl, rw};
				m.addr = {base, xor_product(SEL_INV + int'(dual), r)};
			end
			expected_maps.push_back(m);
		endfunction

		function void compare_field(string name, logic [ADDR_W-1:0] want, logic [ADDR_W-1:0] got);
			if (got !== want) begin
				$error("%s: expected %h, got %h", name, want, got);
				errors++;
			end
		endfunction

		function void check_result(logic [M_DATA_W-1:0] d);
			map_result_t want;
			if (expected_maps.size() == 0) begin
				$error("result %h arrived with no request outstanding", d);
				errors++;
				return;
			end
			want = expected_maps.pop_front();
			compare_field("bank_out", ADDR_W'(want.bank), ADDR_W'(d[4:0]));
			compare_field("row_out", ADDR_W'(want.row), ADDR_W'(d[17:5]));
			compare_field("col_out", ADDR_W'(want.col), ADDR_W'(d[30:18]));
			compare_field("address_out", want.addr, d[94:31]);
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [BASE_W-1:0]      cfg_wdata;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [S_DATA_W-1:0]    s_tdata;
	logic                   s_tuser;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [M_DATA_W-1:0]    m_tdata;

	bit             idle_on;
	int             rx_hold;
	int             n_settings;
	xor_map_tracker tracker;

	dram_xor_address_mapper i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always #10 clk = ~clk;

	// Receiver: check on the handshake, then pick the next ready level.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			tracker.check_result(m_tdata);
		end
		if (rx_hold > 0) begin
			rx_hold--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= !(idle_on && $urandom_range(99) < 14);
		end
	end

	task automatic push_request(op_t op, word_t a, logic [BANK_W-1:0] bk,
			logic [ROW_W-1:0] rw, logic [COL_W-1:0] cl);
		while (idle_on && $urandom_range(99) < 14) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {3'b000, cl, rw, bk, a};
		do @(posedge clk); while (!s_tready);
		tracker.note_request(op, a, bk, rw, cl);
	endtask

	task automatic push_random();
		word_t a;
		case ($urandom_range(7))
			0:       a = '1;
			1:       a = '0;
			2:       a = word_t'(1) << $urandom_range(MAPPED_BITS - 1);
			default: a = word_t'($urandom);
		endcase
		push_request(op_t'($urandom_range(1)), a, BANK_W'($urandom), ROW_W'($urandom),
			COL_W'($urandom));
	endtask

	// Hold the input low until every outstanding request has come back.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (tracker.pending() != 0) @(posedge clk);
	endtask

	task automatic write_regs(logic dual, logic [BASE_W-1:0] base);
		logic [BASE_W-1:0] dual_word;
		dual_word    = {2'($urandom), 32'($urandom)};
		dual_word[0] = dual;
		drain();
		cfg_we    <= 1'b1;
		cfg_index <= REG_DUAL_RANK;
		cfg_wdata <= dual_word;
		@(posedge clk);
		cfg_index <= REG_BASE_PAGE;
		cfg_wdata <= base;
		@(posedge clk);
		cfg_we <= 1'b0;
		tracker.set_reg(REG_DUAL_RANK, dual_word);
		tracker.set_reg(REG_BASE_PAGE, base);
		n_settings++;
	endtask

	// Field extremes, single taps of the paired rows and bits that the layout masks off.
	task automatic run_directed();
		push_request(OP_FWD, '0, BANK_W'($urandom), ROW_W'($urandom), COL_W'($urandom));
		push_request(OP_FWD, '1, BANK_W'($urandom), ROW_W'($urandom), COL_W'($urandom));
		push_request(OP_FWD, word_t'(1) << 6, '0, '0, '0);
		push_request(OP_FWD, word_t'(1) << 13, '1, '1, '1);
		push_request(OP_FWD, word_t'(1) << 17, '0, '0, '0);
		push_request(OP_FWD, word_t'(1) << 29, '0, '0, '0);
		push_request(OP_REV, word_t'($urandom), '0, '0, '0);
		push_request(OP_REV, word_t'($urandom), '1, '1, '1);
		push_request(OP_REV, '0, 5'd16, '0, '0);
		push_request(OP_REV, '0, '0, 13'd4096, '0);
		push_request(OP_REV, '1, '0, '0, 13'd4096);
	endtask

	initial begin
		logic              dual;
		logic [BASE_W-1:0] base;
		tracker    = new();
		idle_on    = 1'b1;
		rx_hold    = 0;
		n_settings = 0;
		arst_n     <= 1'b0;
		cfg_we     <= 1'b0;
		cfg_index  <= REG_DUAL_RANK;
		cfg_wdata  <= '0;
		s_tvalid   <= 1'b0;
		s_tdata    <= '0;
		s_tuser    <= OP_FWD;
		m_tready   <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_regs(1'b0, '0);
		run_directed();
		write_regs(1'b1, '1);
		run_directed();

		for (int p = 0; p < 5; p++) begin
			case (p)
				0:       begin dual = 1'b0; base = {2'($urandom), 32'($urandom)}; end
				1:       begin dual = 1'b1; base = {2'($urandom), 32'($urandom)}; end
				2:       begin dual = 1'b1; base = '1; end
				3:       begin dual = 1'b0; base = '0; end
				default: begin dual = 1'b1; base = {2'($urandom), 32'($urandom)}; end
			endcase
			write_regs(dual, base);
			// One phase runs flat out on both sides.
			idle_on = (p != 1);
			// Stall the receiver long enough to back the pipeline up into the input.
			if (p == 2) begin
				rx_hold = 80;
			end
			for (int i = 0; i < 136; i++) begin
				if (p == 3 && i == 68) begin
					drain();
				end
				push_random();
			end
		end

		drain();
		repeat (8) @(posedge clk);
		$display("tb: %0d forward and %0d reverse requests checked", tracker.n_fwd, tracker.n_rev);
		$display("tb: %0d register settings across both rank modes, base page extremes included",
			n_settings);
		if (tracker.errors == 0 && tracker.pending() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	initial begin
		#4000000;
		$display("tb: failure");
		$finish;
	end

endmodule

### filelist.f
+incdir+rtl
rtl/dxam_pkg.sv
rtl/dram_xor_address_mapper.sv
verif/dram_xor_address_mapper_tb.sv
